>>> hw/rtl/bppt_pkg.sv
// Package for the bank port budget tracker: widths, command and register codes,
// controller state type and the saturating credit increment.
// No dependencies.
`timescale 1ns / 1ps

package bppt_pkg;

    localparam int NUM_BANKS = 16;
    localparam int MASK_BITS = 16;
    localparam int CRED_W    = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [CRED_W-1:0] cred_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_RELOAD  = 2'd0,
        CMD_CONSUME = 2'd1,
        CMD_REFUND  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RD_PACKETS_MAX = 2'd0,
        REG_WR_PACKETS_MAX = 2'd1,
        REG_RD_PORTS_MAX   = 2'd2,
        REG_WR_PORTS_MAX   = 2'd3
    } cfg_idx_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    localparam cred_t CRED_MAX_RESET = cred_t'(1);

    // min(v + 1, max), widened so a full counter does not wrap
    function automatic cred_t clamp_inc(input cred_t v, input cred_t max);
        logic [CRED_W:0] n;
        n = {1'b0, v} + {{CRED_W{1'b0}}, 1'b1};
        return (n < {1'b0, max}) ? n[CRED_W-1:0] : max;
    endfunction

endpackage

>>> hw/rtl/bppt_if.sv
// Handshake interfaces for the request, result and configuration channels.
// Depends on bppt_pkg.
`timescale 1ns / 1ps

interface bppt_in_if;
    logic                          valid;
    logic                          ready;
    logic [bppt_pkg::CMD_W-1:0]    command;
    logic                          is_write;
    logic [bppt_pkg::MASK_BITS-1:0] bank_mask;

    modport source (output valid, command, is_write, bank_mask, input ready);
    modport sink   (input valid, command, is_write, bank_mask, output ready);
endinterface

interface bppt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [bppt_pkg::CRED_W-1:0] packets_left;

    modport source (output valid, granted, packets_left, input ready);
    modport sink   (input valid, granted, packets_left, output ready);
endinterface

interface bppt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bppt_pkg::CFG_IDX_W-1:0] index;
    logic [bppt_pkg::CRED_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bank_port_budget_tracker.sv
// Bank port budget tracker: each item is captured into the request register on accept,
// then an execute state checks and updates all bank credit lanes in parallel; one item at a time.
// No new word is taken while the execute state is busy with the last one.
// The result register lets the next word be accepted on the edge the result is taken.
// Reset (async, active low) clears all credits to zero and sets every limit to one.
`timescale 1ns / 1ps

module bank_port_budget_tracker (
    input  logic        clk,
    input  logic        rst_n,
    bppt_in_if.sink     in_ch,
    bppt_out_if.source  out_ch,
    bppt_cfg_if.sink    cfg
);
    import bppt_pkg::*;

    ctrl_t ctrl;

    // limit writes are always taken
    assign cfg.ready = 1'b1;

    bppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctrl      (ctrl)
    );

    bppt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (in_ch.command),
        .is_write     (in_ch.is_write),
        .bank_mask    (in_ch.bank_mask),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .granted      (out_ch.granted),
        .packets_left (out_ch.packets_left)
    );

endmodule

>>> hw/rtl/bppt_ctrl.sv
// Controller for the bank port budget tracker: request sequencing and result valid.
// Depends on bppt_pkg.
`timescale 1ns / 1ps

module bppt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output bppt_pkg::ctrl_t ctrl
);
    import bppt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;

    // take a new word only when the result slot is empty or draining this edge
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        case (state_reg)
            ST_IDLE: ctrl.capture = accept;
            ST_EXEC: ctrl.execute = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        if (ctrl.execute)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/bppt_datapath.sv
// Datapath for the bank port budget tracker: limit registers, packet and
// per-bank credit counters, grant check and result register. Depends on bppt_pkg.
`timescale 1ns / 1ps

module bppt_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bppt_pkg::ctrl_t                ctrl,
    input  logic [bppt_pkg::CMD_W-1:0]     command,
    input  logic                           is_write,
    input  logic [bppt_pkg::MASK_BITS-1:0] bank_mask,
    input  logic                           cfg_we,
    input  logic [bppt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bppt_pkg::CRED_W-1:0]    cfg_data,
    output logic                           granted,
    output logic [bppt_pkg::CRED_W-1:0]    packets_left
);
    import bppt_pkg::*;

    // limit registers
    cred_t rd_pkt_max_reg;
    cred_t wr_pkt_max_reg;
    cred_t rd_port_max_reg;
    cred_t wr_port_max_reg;

    // captured request word
    cmd_t                 cmd_reg;
    logic                 wr_reg;
    logic [MASK_BITS-1:0] mask_reg;

    // credit state
    cred_t rd_pkt_reg;
    cred_t rd_pkt_next;
    cred_t wr_pkt_reg;
    cred_t wr_pkt_next;
    cred_t rd_bank_reg  [NUM_BANKS];
    cred_t rd_bank_next [NUM_BANKS];
    cred_t wr_bank_reg  [NUM_BANKS];
    cred_t wr_bank_next [NUM_BANKS];

    // result
    logic  granted_reg;
    logic  granted_next;
    cred_t left_reg;
    cred_t left_next;

    logic [NUM_BANKS-1:0] touched;
    logic [NUM_BANKS-1:0] hit_zero;
    cred_t                sel_pkt;
    logic                 grant_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pkt_max_reg  <= CRED_MAX_RESET;
            wr_pkt_max_reg  <= CRED_MAX_RESET;
            rd_port_max_reg <= CRED_MAX_RESET;
            wr_port_max_reg <= CRED_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RD_PACKETS_MAX: rd_pkt_max_reg  <= cfg_data;
                REG_WR_PACKETS_MAX: wr_pkt_max_reg  <= cfg_data;
                REG_RD_PORTS_MAX:   rd_port_max_reg <= cfg_data;
                REG_WR_PORTS_MAX:   wr_port_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= cmd_t'(command);
            wr_reg   <= is_write;
            mask_reg <= bank_mask;
        end
    end

    assign sel_pkt  = wr_reg ? wr_pkt_reg : rd_pkt_reg;
    assign grant_ok = (sel_pkt != '0) && !(|hit_zero);

    // one lane per bank; banks beyond the mask width are never touched
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        if (b < MASK_BITS)
        begin : g_mask
            assign touched[b] = mask_reg[b];
        end
        else
        begin : g_none
            assign touched[b] = 1'b0;
        end

        assign hit_zero[b] = touched[b] &&
                             ((wr_reg ? wr_bank_reg[b] : rd_bank_reg[b]) == '0);

        always_comb
        begin
            rd_bank_next[b] = rd_bank_reg[b];
            wr_bank_next[b] = wr_bank_reg[b];
            if (ctrl.execute)
            begin
                case (cmd_reg)
                    CMD_RELOAD:
                    begin
                        rd_bank_next[b] = rd_port_max_reg;
                        wr_bank_next[b] = wr_port_max_reg;
                    end
                    CMD_CONSUME:
                    begin
                        if (grant_ok && touched[b])
                        begin
                            if (wr_reg)
                                wr_bank_next[b] = wr_bank_reg[b] - cred_t'(1);
                            else
                                rd_bank_next[b] = rd_bank_reg[b] - cred_t'(1);
                        end
                    end
                    CMD_REFUND:
                    begin
                        if (touched[b])
                        begin
                            if (wr_reg)
                                wr_bank_next[b] = clamp_inc(wr_bank_reg[b], wr_port_max_reg);
                            else
                                rd_bank_next[b] = clamp_inc(rd_bank_reg[b], rd_port_max_reg);
                        end
                    end
                    default: ;
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rd_bank_reg[b] <= '0;
                wr_bank_reg[b] <= '0;
            end
            else
            begin
                rd_bank_reg[b] <= rd_bank_next[b];
                wr_bank_reg[b] <= wr_bank_next[b];
            end
        end
    end

    always_comb
    begin
        rd_pkt_next  = rd_pkt_reg;
        wr_pkt_next  = wr_pkt_reg;
        granted_next = 1'b0;
        case (cmd_reg)
            CMD_RELOAD:
            begin
                rd_pkt_next  = rd_pkt_max_reg;
                wr_pkt_next  = wr_pkt_max_reg;
                granted_next = 1'b1;
            end
            CMD_CONSUME:
            begin
                if (grant_ok)
                begin
                    if (wr_reg)
                        wr_pkt_next = wr_pkt_reg - cred_t'(1);
                    else
                        rd_pkt_next = rd_pkt_reg - cred_t'(1);
                    granted_next = 1'b1;
                end
            end
            CMD_REFUND:
            begin
                if (wr_reg)
                    wr_pkt_next = clamp_inc(wr_pkt_reg, wr_pkt_max_reg);
                else
                    rd_pkt_next = clamp_inc(rd_pkt_reg, rd_pkt_max_reg);
                granted_next = 1'b1;
            end
            default: ;
        endcase
        left_next = wr_reg ? wr_pkt_next : rd_pkt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pkt_reg <= '0;
            wr_pkt_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            rd_pkt_reg <= rd_pkt_next;
            wr_pkt_reg <= wr_pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            granted_reg <= granted_next;
            left_reg    <= left_next;
        end
    end

    assign granted      = granted_reg;
    assign packets_left = left_reg;

endmodule

>>> hw/rtl/bppt_checker.sv
// Port-level checks for the bank port budget tracker, bound to the top level.
// Depends on bppt_pkg and bank_port_budget_tracker.
`timescale 1ns / 1ps

module bppt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [bppt_pkg::CMD_W-1:0]  command,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        granted,
    input logic [bppt_pkg::CRED_W-1:0] packets_left
);
    import bppt_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("request accepted while previous word in flight");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> ##1 out_valid)
        else $error("result not valid two cycles after accept");

    a_reload_refund_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (command == CMD_RELOAD || command == CMD_REFUND)) |=> ##1 granted)
        else $error("reload or refund not granted");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(granted) && $stable(packets_left)))
        else $error("stalled result changed");

endmodule

bind bank_port_budget_tracker bppt_checker u_bppt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .command      (in_ch.command),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .granted      (out_ch.granted),
    .packets_left (out_ch.packets_left)
);

>>> bench/tb.sv
// Self-checking bench for bank_port_budget_tracker: drives request words and
// limit writes, predicts every grant and packet count, and checks each result.
// Depends on bppt_pkg, the bppt interfaces and the tracker RTL.
`timescale 1ns / 1ps

module tb;
    import bppt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_WORDS  = 140;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [CMD_W-1:0]     command;
        logic                 is_write;
        logic [MASK_BITS-1:0] bank_mask;
    } req_word_t;

    typedef struct {
        logic  granted;
        cred_t packets_left;
    } grant_t;

    logic clk;
    logic rst_n;

    bppt_in_if  req_ch ();
    bppt_out_if res_ch ();
    bppt_cfg_if cfg_ch ();

    bank_port_budget_tracker uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch),
        .cfg    (cfg_ch)
    );

    // pool index 0 is read, 1 is write
    cred_t pkt_credit [2];
    cred_t bank_credit [2][NUM_BANKS];
    cred_t pkt_limit [2];
    cred_t port_limit [2];

    req_word_t send_q [$];
    grant_t    grant_q [$];

    logic      req_taken;
    logic      idle_on;
    int        hold_asked;
    int        hold_served;
    int        hold_left;
    int        stall_left;
    int        send_gap;
    int        mismatches;
    int        quiet_cycles;
    req_word_t next_word;

    always #2 clk = ~clk;

    function automatic cred_t step_up(input cred_t v, input cred_t limit);
        int n;
        n = int'(v) + 1;
        return (n < int'(limit)) ? cred_t'(n) : limit;
    endfunction

    // advance the credit state by one request word and give the expected result
    function automatic grant_t predict_grant(input req_word_t w);
        grant_t r;
        int     p;
        int     b;
        logic   avail;
        p = w.is_write ? 1 : 0;
        r.granted = 1'b1;
        case (w.command)
            CMD_RELOAD:
            begin
                for (int q = 0; q < 2; q++)
                begin
                    pkt_credit[q] = pkt_limit[q];
                    for (b = 0; b < NUM_BANKS; b++)
                        bank_credit[q][b] = port_limit[q];
                end
            end
            CMD_CONSUME:
            begin
                avail = (pkt_credit[p] != 0);
                for (b = 0; b < NUM_BANKS && b < MASK_BITS; b++)
                    if (w.bank_mask[b] && bank_credit[p][b] == 0)
                        avail = 1'b0;
                if (avail)
                begin
                    pkt_credit[p] = pkt_credit[p] - cred_t'(1);
                    for (b = 0; b < NUM_BANKS && b < MASK_BITS; b++)
                        if (w.bank_mask[b])
                            bank_credit[p][b] = bank_credit[p][b] - cred_t'(1);
                end
                r.granted = avail;
            end
            CMD_REFUND:
            begin
                pkt_credit[p] = step_up(pkt_credit[p], pkt_limit[p]);
                for (b = 0; b < NUM_BANKS && b < MASK_BITS; b++)
                    if (w.bank_mask[b])
                        bank_credit[p][b] = step_up(bank_credit[p][b], port_limit[p]);
            end
            default:
                r.granted = 1'b0;
        endcase
        r.packets_left = pkt_credit[p];
        return r;
    endfunction

    function automatic void note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic req_word_t random_request();
        req_word_t w;
        int        pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            w.command = CMD_RELOAD;
        else if (pick < 12)
            w.command = CMD_CONSUME;
        else if (pick < 18)
            w.command = CMD_REFUND;
        else
            w.command = CMD_UNUSED;
        w.is_write = 1'($urandom_range(0, 1));
        // mostly sparse masks so consumes get past the bank checks
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w.bank_mask = '0;
        else if (pick == 1)
            w.bank_mask = '1;
        else if (pick < 6)
            w.bank_mask = MASK_BITS'(1 << $urandom_range(0, MASK_BITS - 1));
        else if (pick < 8)
            w.bank_mask = MASK_BITS'((1 << $urandom_range(0, MASK_BITS - 1))
                                   | (1 << $urandom_range(0, MASK_BITS - 1)));
        else
            w.bank_mask = MASK_BITS'($urandom);
        return w;
    endfunction

    task automatic send(input logic [CMD_W-1:0] c, input logic wr,
                        input logic [MASK_BITS-1:0] m);
        req_word_t w;
        w.command   = c;
        w.is_write  = wr;
        w.bank_mask = m;
        send_q.push_back(w);
    endtask

    // wait until every queued word has been sent and every result has come back
    task automatic drain();
        do
            @(posedge clk);
        while (send_q.size() != 0 || req_ch.valid || grant_q.size() != 0);
    endtask

    task automatic write_limit(input cfg_idx_t idx, input cred_t val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_limits(input cred_t rdp, input cred_t wrp,
                               input cred_t rdb, input cred_t wrb);
        write_limit(REG_RD_PACKETS_MAX, rdp);
        write_limit(REG_WR_PACKETS_MAX, wrp);
        write_limit(REG_RD_PORTS_MAX, rdb);
        write_limit(REG_WR_PORTS_MAX, wrb);
    endtask

    // request driver: hold the word until taken, then idle or present the next
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!(req_ch.valid && !req_taken))
        begin
            if (send_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap = $urandom_range(0, 4);
            end
            else if (send_q.size() != 0)
            begin
                next_word = send_q.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.command   <= next_word.command;
                req_ch.is_write  <= next_word.is_write;
                req_ch.bank_mask <= next_word.bank_mask;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver: long hold-off on request, otherwise random stall bursts while idle_on is set
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b1;
        else if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        grant_t    want;
        req_word_t seen;
        logic      req_fire;
        logic      res_fire;
        logic      cfg_fire;
        if (rst_n)
        begin
            req_fire = req_ch.valid && req_ch.ready;
            res_fire = res_ch.valid && res_ch.ready;
            cfg_fire = cfg_ch.valid && cfg_ch.ready;
            req_taken <= req_fire;

            // check before predicting, so a result never matches its own word
            if (res_fire)
            begin
                if (grant_q.size() == 0)
                    note_error($sformatf("unexpected result granted=%0d packets_left=%0d",
                                         res_ch.granted, res_ch.packets_left));
                else
                begin
                    want = grant_q.pop_front();
                    if (res_ch.granted !== want.granted
                        || res_ch.packets_left !== want.packets_left)
                        note_error($sformatf({"mismatch: expected granted=%0d ",
                                              "packets_left=%0d, got granted=%0d ",
                                              "packets_left=%0d"},
                                             want.granted, want.packets_left,
                                             res_ch.granted, res_ch.packets_left));
                end
            end

            if (req_fire)
            begin
                seen.command   = req_ch.command;
                seen.is_write  = req_ch.is_write;
                seen.bank_mask = req_ch.bank_mask;
                grant_q.push_back(predict_grant(seen));
            end

            if (cfg_fire)
            begin
                case (cfg_ch.index)
                    REG_RD_PACKETS_MAX: pkt_limit[0]  = cfg_ch.data;
                    REG_WR_PACKETS_MAX: pkt_limit[1]  = cfg_ch.data;
                    REG_RD_PORTS_MAX:   port_limit[0] = cfg_ch.data;
                    REG_WR_PORTS_MAX:   port_limit[1] = cfg_ch.data;
                    default: ;
                endcase
            end

            if (req_fire || res_fire || cfg_fire)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        cred_t lim_tab [6][4];

        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_RELOAD;
        req_ch.is_write = 1'b0;
        req_ch.bank_mask = '0;
        res_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_RD_PACKETS_MAX;
        cfg_ch.data = '0;
        req_taken = 1'b0;
        idle_on = 1'b1;
        hold_asked = 0;
        hold_served = 0;
        hold_left = 0;
        stall_left = 0;
        send_gap = 0;
        mismatches = 0;
        quiet_cycles = 0;

        // state after reset: credits empty, every limit at one
        for (int q = 0; q < 2; q++)
        begin
            pkt_credit[q] = '0;
            pkt_limit[q]  = CRED_MAX_RESET;
            port_limit[q] = CRED_MAX_RESET;
            for (int b = 0; b < NUM_BANKS; b++)
                bank_credit[q][b] = '0;
        end

        lim_tab = '{'{4'd15, 4'd15, 4'd15, 4'd15},
                    '{4'd0,  4'd0,  4'd0,  4'd0},
                    '{4'd3,  4'd5,  4'd2,  4'd4},
                    '{4'd1,  4'd1,  4'd1,  4'd1},
                    '{4'd15, 4'd0,  4'd0,  4'd15},
                    '{4'd2,  4'd2,  4'd2,  4'd2}};
        for (int r = 0; r < 4; r++)
            lim_tab[5][r] = cred_t'($urandom_range(1, 15));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits: empty pools refuse, refund fills to one, unused command
        @(posedge clk);
        send(CMD_CONSUME, 1'b0, 16'h0001);
        send(CMD_REFUND,  1'b1, 16'h8000);
        send(CMD_UNUSED,  1'b0, 16'hFFFF);
        send(CMD_RELOAD,  1'b1, 16'h0000);
        send(CMD_CONSUME, 1'b0, 16'hFFFF);
        send(CMD_CONSUME, 1'b0, 16'h0000);
        drain();

        // full limits: saturating refund, all banks touched, empty mask
        load_limits(4'd15, 4'd15, 4'd15, 4'd15);
        @(posedge clk);
        send(CMD_RELOAD,  1'b0, 16'h1234);
        send(CMD_CONSUME, 1'b1, 16'hFFFF);
        send(CMD_CONSUME, 1'b0, 16'h0000);
        send(CMD_REFUND,  1'b0, 16'hFFFF);
        send(CMD_UNUSED,  1'b1, 16'hAAAA);
        send(CMD_CONSUME, 1'b0, 16'h5555);
        drain();

        // lower limits below the loaded credit: refund drops down to the limit
        load_limits(4'd2, 4'd15, 4'd0, 4'd15);
        @(posedge clk);
        send(CMD_REFUND,  1'b0, 16'h0001);
        send(CMD_CONSUME, 1'b0, 16'h0001);
        send(CMD_CONSUME, 1'b0, 16'h0002);
        send(CMD_RELOAD,  1'b1, 16'hFFFF);
        send(CMD_CONSUME, 1'b0, 16'h0000);
        send(CMD_CONSUME, 1'b0, 16'h8000);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_limits(lim_tab[ph][0], lim_tab[ph][1], lim_tab[ph][2], lim_tab[ph][3]);
            @(posedge clk);
            if (ph == 5)
                idle_on = 1'b0;
            send(CMD_RELOAD, ph[0], '0);
            for (int i = 1; i < PHASE_WORDS; i++)
                send_q.push_back(random_request());
            // starve the result side so the tracker backs up into its input
            if (ph == 2)
                hold_asked = hold_asked + 1;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
